// ===== design/ntp_pkg.sv =====
// ntp_pkg: shared types, parse phase codes and character helpers for the
// number token parser. No dependencies.
package ntp_pkg;

    // parse phase codes
    localparam logic [3:0] PH_START      = 4'd0;
    localparam logic [3:0] PH_ZERO       = 4'd1;
    localparam logic [3:0] PH_PREFIX     = 4'd2;
    localparam logic [3:0] PH_INT        = 4'd3;
    localparam logic [3:0] PH_FRAC       = 4'd4;
    localparam logic [3:0] PH_EXP_START  = 4'd5;
    localparam logic [3:0] PH_EXP_SIGN   = 4'd6;
    localparam logic [3:0] PH_EXP_DIGITS = 4'd7;
    localparam logic [3:0] PH_BAD        = 4'd8;

    // radix limits
    localparam logic [5:0] BASE_RESET = 6'd10;
    localparam logic [5:0] BASE_MIN   = 6'd2;
    localparam logic [5:0] BASE_MAX   = 6'd36;
    localparam logic [5:0] HEX_RADIX  = 6'd16;
    localparam logic [5:0] DEC_RADIX  = 6'd10;

    // characters
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;

    // per-token control state
    typedef struct packed {
        logic [3:0] phase;
        logic       neg;
        logic       hex;
        logic       sat;
        logic       digit;
    } t_flags;

    localparam t_flags FLAGS_CLEAR = '{phase: PH_START, neg: 1'b0, hex: 1'b0,
                                       sat: 1'b0, digit: 1'b0};

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_digit;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_digit digit_value(input logic [7:0] c);
        t_digit d;
        d.ok  = 1'b1;
        d.val = 6'd0;
        if (is_dec(c)) begin
            d.val = 6'(c - CH_ZERO);
        end else if ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) begin
            d.val = 6'(c - CH_LOW_A) + 6'd10;
        end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
            d.val = 6'(c - CH_UP_A) + 6'd10;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== design/ntp_step.sv =====
// ntp_step: one character of token parsing, next state and token result.
// Depends on ntp_pkg.
module ntp_step #(
    parameter int VALUE_BITS = 32
) (
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    input  logic [5:0]            i_base,
    input  ntp_pkg::t_flags       i_flags,
    input  logic [VALUE_BITS-1:0] i_acc,
    output ntp_pkg::t_flags       o_flags,
    output logic [VALUE_BITS-1:0] o_acc,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_not_number,
    output logic                  o_float_form
);

    localparam int PW = VALUE_BITS + 7;
    localparam logic [PW-1:0] MAG_MAX = PW'({1'b0, {(VALUE_BITS-1){1'b1}}});

    logic [5:0]      radix;
    ntp_pkg::t_digit dig;
    logic [PW-1:0]   prod;
    logic            over;
    logic            decimal;

    assign radix   = i_flags.hex ? ntp_pkg::HEX_RADIX : i_base;
    assign decimal = !i_flags.hex && (i_base == ntp_pkg::DEC_RADIX);
    assign dig     = ntp_pkg::digit_value(i_char);
    // acc * radix + d, wide enough that nothing wraps
    assign prod    = PW'(i_acc) * PW'(radix) + PW'(dig.val);
    assign over    = prod > MAG_MAX;

    always_comb begin
        ntp_pkg::t_flags       f;
        logic [VALUE_BITS-1:0] acc;
        logic                  do_int;

        f      = i_flags;
        acc    = i_acc;
        do_int = 1'b0;

        case (i_flags.phase)
            ntp_pkg::PH_START: begin
                if (i_char == ntp_pkg::CH_DOLLAR) begin
                    f.hex   = 1'b1;
                    f.phase = ntp_pkg::PH_PREFIX;
                end else if (i_char == ntp_pkg::CH_ZERO) begin
                    f.digit = 1'b1;
                    acc     = '0;
                    f.phase = ntp_pkg::PH_ZERO;
                end else if (i_char == ntp_pkg::CH_MINUS) begin
                    f.neg   = 1'b1;
                    f.phase = ntp_pkg::PH_INT;
                end else begin
                    f.phase = ntp_pkg::PH_INT;
                    do_int  = 1'b1;
                end
            end
            ntp_pkg::PH_ZERO: begin
                if (i_char == ntp_pkg::CH_LOW_X || i_char == ntp_pkg::CH_UP_X) begin
                    f.hex   = 1'b1;
                    acc     = '0;
                    f.digit = 1'b0;
                    f.phase = ntp_pkg::PH_PREFIX;
                end else begin
                    f.phase = ntp_pkg::PH_INT;
                    do_int  = 1'b1;
                end
            end
            ntp_pkg::PH_PREFIX: begin
                f.phase = ntp_pkg::PH_INT;
                if (i_char == ntp_pkg::CH_MINUS) begin
                    f.neg = 1'b1;
                end else begin
                    do_int = 1'b1;
                end
            end
            ntp_pkg::PH_INT: begin
                do_int = 1'b1;
            end
            ntp_pkg::PH_FRAC: begin
                if (ntp_pkg::is_dec(i_char)) begin
                    f.digit = 1'b1;
                end else if (i_char == ntp_pkg::CH_LOW_E || i_char == ntp_pkg::CH_UP_E) begin
                    f.phase = ntp_pkg::PH_EXP_START;
                end else begin
                    f.phase = ntp_pkg::PH_BAD;
                end
            end
            ntp_pkg::PH_EXP_START: begin
                if (i_char == ntp_pkg::CH_MINUS) begin
                    f.phase = ntp_pkg::PH_EXP_SIGN;
                end else if (ntp_pkg::is_dec(i_char)) begin
                    f.phase = ntp_pkg::PH_EXP_DIGITS;
                end else begin
                    f.phase = ntp_pkg::PH_BAD;
                end
            end
            ntp_pkg::PH_EXP_SIGN, ntp_pkg::PH_EXP_DIGITS: begin
                f.phase = ntp_pkg::is_dec(i_char) ? ntp_pkg::PH_EXP_DIGITS
                                                  : ntp_pkg::PH_BAD;
            end
            default: begin
                f.phase = ntp_pkg::PH_BAD;
            end
        endcase

        // integer-part character
        if (do_int) begin
            if (decimal) begin
                if (ntp_pkg::is_dec(i_char)) begin
                    acc     = prod[VALUE_BITS-1:0];
                    f.digit = 1'b1;
                end else if (i_char == ntp_pkg::CH_DOT) begin
                    f.phase = ntp_pkg::PH_FRAC;
                end else if (i_char == ntp_pkg::CH_LOW_E || i_char == ntp_pkg::CH_UP_E) begin
                    f.phase = ntp_pkg::PH_EXP_START;
                end else begin
                    f.phase = ntp_pkg::PH_BAD;
                end
            end else if (!dig.ok || dig.val >= radix) begin
                f.phase = ntp_pkg::PH_BAD;
            end else begin
                f.digit = 1'b1;
                if (!f.sat) begin
                    if (over) begin
                        f.sat = 1'b1;
                        acc   = MAG_MAX[VALUE_BITS-1:0];
                    end else begin
                        acc = prod[VALUE_BITS-1:0];
                    end
                end
            end
        end

        // token result
        o_value      = '0;
        o_not_number = 1'b1;
        o_float_form = 1'b0;
        if (f.phase == ntp_pkg::PH_ZERO || f.phase == ntp_pkg::PH_PREFIX ||
            f.phase == ntp_pkg::PH_INT) begin
            if (f.digit) begin
                o_not_number = 1'b0;
                o_value      = f.neg ? (VALUE_BITS'(0) - acc) : acc;
            end
        end else if (f.phase == ntp_pkg::PH_FRAC || f.phase == ntp_pkg::PH_EXP_DIGITS) begin
            if (f.digit) begin
                o_not_number = 1'b0;
                o_float_form = 1'b1;
            end
        end

        if (i_last) begin
            f   = ntp_pkg::FLAGS_CLEAR;
            acc = '0;
        end

        o_flags = f;
        o_acc   = acc;
    end

endmodule

// ===== design/number_token_parser.sv =====
// number_token_parser: streaming conversion of a text token into an integer.
// Depends on ntp_pkg and ntp_step.
// result path: a final character waits in the input register, and its result is then
//   registered in the output register, which drives o_valid
// throughput: one character per cycle, set by the single multiply-add by the radix;
//   a final character stalls in the input register while a result waits unread
// reset: synchronous active-low i_rst_n clears token state, both valids, radix to 10
module number_token_parser #(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: radix
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data,
    // character stream
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_last_char,
    // token results
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value,
    output logic        o_not_number,
    output logic        o_float_form
);

    // configured radix, clamped on write
    logic [5:0] r_base;
    logic [5:0] n_base;

    // input register
    logic       r_in_vld;
    logic [7:0] r_char;
    logic       r_last;

    // token state
    ntp_pkg::t_flags       r_flags;
    logic [VALUE_BITS-1:0] r_acc;
    ntp_pkg::t_flags       n_flags;
    logic [VALUE_BITS-1:0] n_acc;

    // result of the character in the input register
    logic [VALUE_BITS-1:0] step_value;
    logic                  step_nan;
    logic                  step_flt;
    logic [31:0]           n_value;

    // output register
    logic        r_out_vld;
    logic [31:0] r_value;
    logic        r_nan;
    logic        r_flt;

    logic out_free;
    logic advance;

    // output slot can take a result this cycle
    assign out_free = !r_out_vld || i_ready;
    // the held character is consumed; a final one needs room for its result
    assign advance  = r_in_vld && (!r_last || out_free);
    assign o_ready  = !r_in_vld || advance;

    always_comb begin
        if (i_cfg_data < ntp_pkg::BASE_MIN) begin
            n_base = ntp_pkg::BASE_MIN;
        end else if (i_cfg_data > ntp_pkg::BASE_MAX) begin
            n_base = ntp_pkg::BASE_MAX;
        end else begin
            n_base = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= ntp_pkg::BASE_RESET;
        end else if (i_cfg_we) begin
            r_base <= n_base;
        end
    end

    // input register: loads on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_in;
            r_last <= i_last_char;
        end
    end

    ntp_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .i_char       (r_char),
        .i_last       (r_last),
        .i_base       (r_base),
        .i_flags      (r_flags),
        .i_acc        (r_acc),
        .o_flags      (n_flags),
        .o_acc        (n_acc),
        .o_value      (step_value),
        .o_not_number (step_nan),
        .o_float_form (step_flt)
    );

    // token state advances once per consumed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= ntp_pkg::FLAGS_CLEAR;
            r_acc   <= '0;
        end else if (advance) begin
            r_flags <= n_flags;
            r_acc   <= n_acc;
        end
    end

    // fit the result to 32 bits: low bits of a wide value, sign-extend a narrow one
    generate
        if (VALUE_BITS >= 32) begin : g_wide
            assign n_value = step_value[31:0];
        end else begin : g_narrow
            assign n_value = {{(32-VALUE_BITS){step_value[VALUE_BITS-1]}}, step_value};
        end
    endgenerate

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && r_last) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_value <= n_value;
            r_nan   <= step_nan;
            r_flt   <= step_flt;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_value      = r_value;
    assign o_not_number = r_nan;
    assign o_float_form = r_flt;

    // radix stays within its legal range
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base >= ntp_pkg::BASE_MIN && r_base <= ntp_pkg::BASE_MAX)
        else $error("radix out of range");

    // a final character leaves the token state cleared
    a_token_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last |=> r_flags == ntp_pkg::FLAGS_CLEAR && r_acc == '0)
        else $error("token state not cleared after final character");

    // a final character never lands on an unread result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last |-> !r_out_vld || i_ready)
        else $error("result overwritten");

    // invalid and float-form results carry a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_nan || r_flt) |-> r_value == 32'd0)
        else $error("nonzero value on invalid or float token");

    // a token is never both invalid and float form
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_nan && r_flt))
        else $error("invalid and float flags both set");

endmodule

// ===== dv/tb_number_token_parser.sv =====
// tb_number_token_parser: self-checking testbench for the number token parser.
// Depends on ntp_pkg and design/number_token_parser.sv; no files or arguments.
`timescale 1ns / 1ps

module tb_number_token_parser;

    localparam int VALUE_BITS = 32;
    localparam longint unsigned VALUE_MASK = 64'hFFFF_FFFF;
    localparam longint unsigned MAG_MAX = 64'h7FFF_FFFF;
    localparam int unsigned NOT_A_DIGIT = 99;
    localparam int DRAIN_CYCLES = 6;       // idle wait to flush the pipeline
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int PHASE_CHARS = 210;      // characters per random phase
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [31:0] value;
        logic        not_number;
        logic        float_form;
    } t_token_result;

    // predicts token results from transferred characters and checks outputs
    class token_checker;
        int unsigned     radix;
        longint unsigned acc;
        logic [3:0]      phase;
        bit              neg;
        bit              hex;
        bit              sat;
        bit              got_digit;
        t_token_result   expected_tokens[$];
        int              mismatches;

        function new();
            radix = ntp_pkg::BASE_RESET;
            mismatches = 0;
            clear_token();
        endfunction

        function void clear_token();
            acc = 0;
            phase = ntp_pkg::PH_START;
            neg = 0;
            hex = 0;
            sat = 0;
            got_digit = 0;
        endfunction

        function void set_radix(logic [5:0] v);
            if (v < ntp_pkg::BASE_MIN) radix = ntp_pkg::BASE_MIN;
            else if (v > ntp_pkg::BASE_MAX) radix = ntp_pkg::BASE_MAX;
            else radix = v;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function bit dec_char(logic [7:0] c);
            return (c >= ntp_pkg::CH_ZERO) && (c <= ntp_pkg::CH_NINE);
        endfunction

        function int unsigned char_digit(logic [7:0] c);
            if (dec_char(c)) return c - ntp_pkg::CH_ZERO;
            if ((c >= ntp_pkg::CH_LOW_A) && (c <= ntp_pkg::CH_LOW_Z))
                return c - ntp_pkg::CH_LOW_A + 10;
            if ((c >= ntp_pkg::CH_UP_A) && (c <= ntp_pkg::CH_UP_Z))
                return c - ntp_pkg::CH_UP_A + 10;
            return NOT_A_DIGIT;
        endfunction

        // one character of the integer part
        function void int_part(logic [7:0] c);
            int unsigned r;
            int unsigned d;
            r = hex ? ntp_pkg::HEX_RADIX : radix;
            d = char_digit(c);
            if (!hex && r == ntp_pkg::DEC_RADIX) begin
                if (dec_char(c)) begin
                    acc = (acc * 10 + d) & VALUE_MASK;
                    got_digit = 1;
                end else if (c == ntp_pkg::CH_DOT) begin
                    phase = ntp_pkg::PH_FRAC;
                end else if (c == ntp_pkg::CH_LOW_E || c == ntp_pkg::CH_UP_E) begin
                    phase = ntp_pkg::PH_EXP_START;
                end else begin
                    phase = ntp_pkg::PH_BAD;
                end
                return;
            end
            if (d >= r) begin
                phase = ntp_pkg::PH_BAD;
                return;
            end
            got_digit = 1;
            if (sat) return;
            if (acc > (MAG_MAX - d) / r) begin
                sat = 1;
                acc = MAG_MAX;
            end else begin
                acc = acc * r + d;
            end
        endfunction

        function void note_char(logic [7:0] c, logic last);
            t_token_result res;
            case (phase)
                ntp_pkg::PH_START: begin
                    if (c == ntp_pkg::CH_DOLLAR) begin
                        hex = 1;
                        phase = ntp_pkg::PH_PREFIX;
                    end else if (c == ntp_pkg::CH_ZERO) begin
                        got_digit = 1;
                        acc = 0;
                        phase = ntp_pkg::PH_ZERO;
                    end else if (c == ntp_pkg::CH_MINUS) begin
                        neg = 1;
                        phase = ntp_pkg::PH_INT;
                    end else begin
                        phase = ntp_pkg::PH_INT;
                        int_part(c);
                    end
                end
                ntp_pkg::PH_ZERO: begin
                    if (c == ntp_pkg::CH_LOW_X || c == ntp_pkg::CH_UP_X) begin
                        hex = 1;
                        acc = 0;
                        got_digit = 0;
                        phase = ntp_pkg::PH_PREFIX;
                    end else begin
                        phase = ntp_pkg::PH_INT;
                        int_part(c);
                    end
                end
                ntp_pkg::PH_PREFIX: begin
                    phase = ntp_pkg::PH_INT;
                    if (c == ntp_pkg::CH_MINUS) neg = 1;
                    else int_part(c);
                end
                ntp_pkg::PH_INT: int_part(c);
                ntp_pkg::PH_FRAC: begin
                    if (dec_char(c)) got_digit = 1;
                    else if (c == ntp_pkg::CH_LOW_E || c == ntp_pkg::CH_UP_E)
                        phase = ntp_pkg::PH_EXP_START;
                    else phase = ntp_pkg::PH_BAD;
                end
                ntp_pkg::PH_EXP_START: begin
                    if (c == ntp_pkg::CH_MINUS) phase = ntp_pkg::PH_EXP_SIGN;
                    else if (dec_char(c)) phase = ntp_pkg::PH_EXP_DIGITS;
                    else phase = ntp_pkg::PH_BAD;
                end
                ntp_pkg::PH_EXP_SIGN, ntp_pkg::PH_EXP_DIGITS:
                    phase = dec_char(c) ? ntp_pkg::PH_EXP_DIGITS : ntp_pkg::PH_BAD;
                default: phase = ntp_pkg::PH_BAD;
            endcase
            if (!last) return;

            res.value = '0;
            res.not_number = 1'b1;
            res.float_form = 1'b0;
            if (phase == ntp_pkg::PH_ZERO || phase == ntp_pkg::PH_PREFIX ||
                phase == ntp_pkg::PH_INT) begin
                if (got_digit) begin
                    res.not_number = 1'b0;
                    res.value = 32'(acc);
                    if (neg) res.value = 32'd0 - res.value;
                end
            end else if (phase == ntp_pkg::PH_FRAC || phase == ntp_pkg::PH_EXP_DIGITS) begin
                if (got_digit) begin
                    res.not_number = 1'b0;
                    res.float_form = 1'b1;
                end
            end
            expected_tokens.push_back(res);
            clear_token();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [31:0] v, logic nn, logic ff);
            t_token_result exp_res;
            if (expected_tokens.size() == 0) begin
                report($sformatf("result with no token pending (value %h)", v));
                return;
            end
            exp_res = expected_tokens.pop_front();
            if (v !== exp_res.value)
                report($sformatf("value %h, expected %h", v, exp_res.value));
            if (nn !== exp_res.not_number)
                report($sformatf("not_number %b, expected %b", nn, exp_res.not_number));
            if (ff !== exp_res.float_form)
                report($sformatf("float_form %b, expected %b", ff, exp_res.float_form));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_char_in;
    logic        i_last_char;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_value;
    logic        o_not_number;
    logic        o_float_form;

    token_checker tracker;
    logic [7:0]   token_chars[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    int           quiet_cycles;
    int           chars_sent;

    number_token_parser #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_not_number(o_not_number),
        .o_float_form(o_float_form)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // every input known from time zero
    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_char_in = '0;
        i_last_char = 1'b0;
        i_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        chars_sent = 0;
    end

    // long hold-off counter, armed once by the main sequence
    always @(posedge i_clk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // result side: check each transfer, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_result(o_value, o_not_number, o_float_form);
        i_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: ends the run after too many cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one character; valid stays up after the transfer unless a gap is drawn
    task automatic send_char(logic [7:0] c, logic last);
        i_valid <= 1'b1;
        i_char_in <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_char(c, last);
        chars_sent++;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic send_token();
        int i;
        for (i = 0; i < token_chars.size(); i++)
            send_char(token_chars[i], i == token_chars.size() - 1);
    endtask

    task automatic send_text(string s);
        int i;
        token_chars.delete();
        for (i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
        send_token();
    endtask

    // radix writes only with the block idle: no result owed, pipeline flushed
    task automatic write_radix(logic [5:0] v);
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        tracker.set_radix(v);
        i_cfg_we <= 1'b0;
    endtask

    // digit character for value d, letters in either case
    function automatic logic [7:0] digit_char(int unsigned d);
        if (d < 10) return ntp_pkg::CH_ZERO + 8'(d);
        return ($urandom_range(1) ? ntp_pkg::CH_LOW_A : ntp_pkg::CH_UP_A) + 8'(d - 10);
    endfunction

    // well-formed integer in radix r, optionally behind a hex prefix
    function automatic void make_integer(int unsigned r, bit with_prefix);
        int n;
        int k;
        token_chars.delete();
        if (with_prefix) begin
            r = ntp_pkg::HEX_RADIX;
            case ($urandom_range(2))
                0: token_chars.push_back(ntp_pkg::CH_DOLLAR);
                1: begin
                    token_chars.push_back(ntp_pkg::CH_ZERO);
                    token_chars.push_back(ntp_pkg::CH_LOW_X);
                end
                default: begin
                    token_chars.push_back(ntp_pkg::CH_ZERO);
                    token_chars.push_back(ntp_pkg::CH_UP_X);
                end
            endcase
        end
        if ($urandom_range(2) == 0) token_chars.push_back(ntp_pkg::CH_MINUS);
        // mostly short, now and then long enough to wrap or saturate
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
        for (k = 0; k < n; k++) token_chars.push_back(digit_char($urandom_range(r - 1)));
    endfunction

    function automatic void push_decimals(int lo, int hi);
        int n;
        int k;
        n = $urandom_range(lo, hi);
        for (k = 0; k < n; k++) token_chars.push_back(digit_char($urandom_range(9)));
    endfunction

    // decimal float syntax: -?(d+|d+.d*|.d+)([eE]-?d+)?
    function automatic void make_float();
        token_chars.delete();
        if ($urandom_range(1)) token_chars.push_back(ntp_pkg::CH_MINUS);
        case ($urandom_range(2))
            0: push_decimals(1, 5);
            1: begin
                push_decimals(1, 5);
                token_chars.push_back(ntp_pkg::CH_DOT);
                push_decimals(0, 4);
            end
            default: begin
                token_chars.push_back(ntp_pkg::CH_DOT);
                push_decimals(1, 5);
            end
        endcase
        if ($urandom_range(1)) begin
            token_chars.push_back($urandom_range(1) ? ntp_pkg::CH_LOW_E : ntp_pkg::CH_UP_E);
            if ($urandom_range(1)) token_chars.push_back(ntp_pkg::CH_MINUS);
            push_decimals(1, 3);
        end
    endfunction

    function automatic void make_noise();
        int n;
        int k;
        token_chars.delete();
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) token_chars.push_back(8'($urandom_range(255)));
    endfunction

    // mostly well-formed tokens, the rest noise and corrupted integers
    task automatic random_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            make_integer(tracker.radix, $urandom_range(4) == 0);
        end else if (pick < 75) begin
            make_float();
        end else if (pick < 85) begin
            make_noise();
        end else begin
            make_integer(tracker.radix, $urandom_range(4) == 0);
            token_chars[$urandom_range(token_chars.size() - 1)] = 8'($urandom_range(255));
        end
        send_token();
    endtask

    // radix per random phase: both clamps, both extremes, hex, decimal and random
    logic [5:0] phase_radix[8];

    initial begin
        int p;
        int stop_at;
        phase_radix = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd0, 6'd63, 6'd7, 6'd10};
        phase_radix[6] = 6'($urandom_range(63));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed tokens at the reset radix of 10
        send_text("9");
        send_text("0");
        send_text("-");         // sign with no digits
        send_text("$-");        // prefix and sign, no digits
        send_text("0x");        // prefix alone
        send_text("$F");
        send_text("1.e-5");     // float with empty fraction and signed exponent
        send_text(".5");        // float with no integer part
        send_text("1e");        // exponent marker with no exponent
        send_char(8'hFF, 1'b1); // top character code

        // radix change in the middle of a token: second '1' is binary
        send_char(ntp_pkg::CH_ZERO + 8'd1, 1'b0);
        write_radix(6'd2);
        send_char(ntp_pkg::CH_ZERO + 8'd1, 1'b1);

        // random phases, cycling through the idle patterns
        for (p = 0; p < 8; p++) begin
            write_radix(phase_radix[p]);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 49;
                end
                default: begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            // receiver holds off while the sender keeps pushing, to back up the input
            if (p == 4) hold_left <= HOLD_CYCLES;
            stop_at = chars_sent + PHASE_CHARS;
            while (chars_sent < stop_at) random_token();
        end

        // drain: all results in, then a few cycles for anything stray
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d token results never arrived", tracker.pending()));
        if (tracker.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
